>>> sv/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants and the sideband type that travels with each lane's data.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int MAT_DIM = 3;
    localparam int N_ENT   = MAT_DIM * MAT_DIM;

    typedef struct packed {
        logic valid;
        logic neg;
        logic ovf;
        logic sing;
    } mi3_ctl_t;

endpackage

>>> sv/mi3_in_if.sv
// ----------------------------------------------------------------------------
// mi3_in_if
// Matrix channel: nine signed entries, row-major, with valid/ready.
// ----------------------------------------------------------------------------
interface mi3_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] a00;
    logic signed [DATA_WIDTH-1:0] a01;
    logic signed [DATA_WIDTH-1:0] a02;
    logic signed [DATA_WIDTH-1:0] a10;
    logic signed [DATA_WIDTH-1:0] a11;
    logic signed [DATA_WIDTH-1:0] a12;
    logic signed [DATA_WIDTH-1:0] a20;
    logic signed [DATA_WIDTH-1:0] a21;
    logic signed [DATA_WIDTH-1:0] a22;

    modport source (
        output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
        input  ready
    );
    modport sink (
        input  valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
        output ready
    );
endinterface

>>> sv/mi3_out_if.sv
// ----------------------------------------------------------------------------
// mi3_out_if
// Inverse channel: nine signed entries, row-major, singular flag, valid/ready.
// ----------------------------------------------------------------------------
interface mi3_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] b00;
    logic signed [DATA_WIDTH-1:0] b01;
    logic signed [DATA_WIDTH-1:0] b02;
    logic signed [DATA_WIDTH-1:0] b10;
    logic signed [DATA_WIDTH-1:0] b11;
    logic signed [DATA_WIDTH-1:0] b12;
    logic signed [DATA_WIDTH-1:0] b20;
    logic signed [DATA_WIDTH-1:0] b21;
    logic signed [DATA_WIDTH-1:0] b22;
    logic                         singular;

    modport source (
        output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22, singular,
        input  ready
    );
    modport sink (
        input  valid, b00, b01, b02, b10, b11, b12, b20, b21, b22, singular,
        output ready
    );
endinterface

>>> sv/matrix_inverse_3x3.sv
// Throughput: one matrix per cycle while the skid register is empty; nine divider lanes
// each resolve one quotient bit per stage, and a one-item skid register absorbs a
// stalled output.
// Reset: clears every valid bit in the pipeline, the output and the skid register;
// data registers are not reset.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 fixed-point inverse by adjugate: cofactor/determinant front end, nine
// parallel divider lanes, and a merging stage that saturates and flags
// singular matrices.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input logic        clk,
    input logic        rst_n,
    mi3_in_if.sink     mat,
    mi3_out_if.source  inv
);

    localparam int D  = DATA_WIDTH;
    localparam int CW = 2 * D + 1;

    logic                  en;
    logic signed [D-1:0]   m     [N_ENT];
    mi3_ctl_t              det_ctl;
    logic signed [CW-1:0]  cof   [N_ENT];
    logic [3*D-1:0]        dabs;
    mi3_ctl_t              lane_ctl [N_ENT];
    logic [D-1:0]          lane_q   [N_ENT];
    logic signed [D-1:0]   res      [N_ENT];
    logic                  fin_vld;
    logic                  fin_sing;

    logic                  out_vld_reg;
    logic signed [D-1:0]   out_res_reg  [N_ENT];
    logic                  out_sing_reg;
    logic                  skid_vld_reg;
    logic signed [D-1:0]   skid_res_reg [N_ENT];
    logic                  skid_sing_reg;
    logic                  out_free;

    assign en        = !skid_vld_reg;
    assign mat.ready = en;

    assign m[0] = mat.a00;
    assign m[1] = mat.a01;
    assign m[2] = mat.a02;
    assign m[3] = mat.a10;
    assign m[4] = mat.a11;
    assign m[5] = mat.a12;
    assign m[6] = mat.a20;
    assign m[7] = mat.a21;
    assign m[8] = mat.a22;

    mi3_det #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_det (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (mat.valid),
        .m        (m),
        .ctl      (det_ctl),
        .cof      (cof),
        .dabs     (dabs)
    );

    for (genvar r = 0; r < MAT_DIM; r++)
    begin : g_lr
        for (genvar c = 0; c < MAT_DIM; c++)
        begin : g_lc
            localparam int I = r * MAT_DIM + c;
            localparam int T = c * MAT_DIM + r;

            logic [D-1:0] lim;
            logic [D-1:0] mag;
            logic [D-1:0] sat;

            mi3_div #(
                .DATA_WIDTH (DATA_WIDTH),
                .FRAC_BITS  (FRAC_BITS)
            ) u_div (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .ctl_in  (det_ctl),
                .cof     (cof[T]),
                .dabs    (dabs),
                .ctl_out (lane_ctl[I]),
                .qmag    (lane_q[I])
            );

            always_comb
            begin
                lim = {1'b0, {(D-1){1'b1}}} + D'(lane_ctl[I].neg);
                mag = lane_ctl[I].ovf ? '1 : lane_q[I];
                sat = (mag > lim) ? lim : mag;
                if (lane_ctl[I].sing)
                begin
                    res[I] = '0;
                end
                else
                begin
                    res[I] = lane_ctl[I].neg ? -$signed(sat) : $signed(sat);
                end
            end
        end
    end

    assign fin_vld  = lane_ctl[0].valid;
    assign fin_sing = lane_ctl[0].sing;
    assign out_free = !out_vld_reg || inv.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= fin_vld;
            end
        end
        else if (en && fin_vld)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_vld_reg)
            begin
                out_res_reg  <= skid_res_reg;
                out_sing_reg <= skid_sing_reg;
            end
            else
            begin
                out_res_reg  <= res;
                out_sing_reg <= fin_sing;
            end
        end
        else if (en && fin_vld)
        begin
            skid_res_reg  <= res;
            skid_sing_reg <= fin_sing;
        end
    end

    assign inv.valid    = out_vld_reg;
    assign inv.b00      = out_res_reg[0];
    assign inv.b01      = out_res_reg[1];
    assign inv.b02      = out_res_reg[2];
    assign inv.b10      = out_res_reg[3];
    assign inv.b11      = out_res_reg[4];
    assign inv.b12      = out_res_reg[5];
    assign inv.b20      = out_res_reg[6];
    assign inv.b21      = out_res_reg[7];
    assign inv.b22      = out_res_reg[8];
    assign inv.singular = out_sing_reg;

    a_skid_behind_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg
    ) else $error("skid register holds an item while output is empty");

    a_skid_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !inv.ready)
    ) else $error("skid register filled without an output stall");

    a_sing_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_sing_reg) |->
            (out_res_reg[0] == '0 && out_res_reg[1] == '0 && out_res_reg[2] == '0 &&
             out_res_reg[3] == '0 && out_res_reg[4] == '0 && out_res_reg[5] == '0 &&
             out_res_reg[6] == '0 && out_res_reg[7] == '0 && out_res_reg[8] == '0)
    ) else $error("singular result with nonzero entries");

    a_lane_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fin_vld && !en) |=> fin_vld
    ) else $error("lane result dropped while pipeline stalled");

endmodule

>>> sv/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// Seven-stage front end: pairwise products, nine cofactors, determinant by
// expansion along row 0, then its magnitude, sign and zero flag.
// ----------------------------------------------------------------------------
module mi3_det
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [DATA_WIDTH-1:0]   m [N_ENT],
    output mi3_ctl_t                       ctl,
    output logic signed [2*DATA_WIDTH:0]   cof [N_ENT],
    output logic [3*DATA_WIDTH-1:0]        dabs
);

    localparam int D   = DATA_WIDTH;
    localparam int PW  = 2 * D;
    localparam int CW  = 2 * D + 1;
    localparam int TW  = 3 * D + 2;
    localparam int DMW = 3 * D;

    logic [6:0] vld_reg;

    logic signed [D-1:0]   m1_reg  [N_ENT];
    logic signed [PW-1:0]  t2_reg  [N_ENT];
    logic signed [PW-1:0]  u2_reg  [N_ENT];
    logic signed [D-1:0]   r2_reg  [MAT_DIM];
    logic signed [CW-1:0]  c3_reg  [N_ENT];
    logic signed [D-1:0]   r3_reg  [MAT_DIM];
    logic signed [D:0]     lo_op   [MAT_DIM];
    logic signed [D:0]     hi_op   [MAT_DIM];
    logic signed [2*D:0]   lo4_reg [MAT_DIM];
    logic signed [2*D:0]   hi4_reg [MAT_DIM];
    logic signed [CW-1:0]  c4_reg  [N_ENT];
    logic signed [TW-1:0]  tm5_reg [MAT_DIM];
    logic signed [CW-1:0]  c5_reg  [N_ENT];
    logic signed [TW-1:0]  det6_reg;
    logic signed [CW-1:0]  c6_reg  [N_ENT];
    logic [DMW-1:0]        dabs7_reg;
    logic                  dneg7_reg;
    logic                  dzero7_reg;
    logic signed [CW-1:0]  c7_reg  [N_ENT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    for (genvar r = 0; r < MAT_DIM; r++)
    begin : g_row
        for (genvar c = 0; c < MAT_DIM; c++)
        begin : g_col
            localparam int R1 = (r + 1) % MAT_DIM;
            localparam int R2 = (r + 2) % MAT_DIM;
            localparam int C1 = (c + 1) % MAT_DIM;
            localparam int C2 = (c + 2) % MAT_DIM;
            localparam int I  = r * MAT_DIM + c;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    t2_reg[I] <= m1_reg[R1*MAT_DIM+C1] * m1_reg[R2*MAT_DIM+C2];
                    u2_reg[I] <= m1_reg[R1*MAT_DIM+C2] * m1_reg[R2*MAT_DIM+C1];
                    c3_reg[I] <= CW'(t2_reg[I]) - CW'(u2_reg[I]);
                end
            end
        end
    end

    for (genvar k = 0; k < MAT_DIM; k++)
    begin : g_term
        assign lo_op[k] = $signed({1'b0, c3_reg[k][D-1:0]});
        assign hi_op[k] = $signed(c3_reg[k][CW-1:D]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r2_reg[k]  <= m1_reg[k];
                r3_reg[k]  <= r2_reg[k];
                lo4_reg[k] <= r3_reg[k] * lo_op[k];
                hi4_reg[k] <= r3_reg[k] * hi_op[k];
                tm5_reg[k] <= (TW'(hi4_reg[k]) <<< D) + TW'(lo4_reg[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg     <= m;
            c4_reg     <= c3_reg;
            c5_reg     <= c4_reg;
            c6_reg     <= c5_reg;
            c7_reg     <= c6_reg;
            det6_reg   <= tm5_reg[0] + tm5_reg[1] + tm5_reg[2];
            dabs7_reg  <= DMW'(det6_reg[TW-1] ? -det6_reg : det6_reg);
            dneg7_reg  <= det6_reg[TW-1];
            dzero7_reg <= (det6_reg == '0);
        end
    end

    always_comb
    begin
        ctl.valid = vld_reg[6];
        ctl.neg   = dneg7_reg;
        ctl.ovf   = 1'b0;
        ctl.sing  = dzero7_reg;
    end

    assign cof  = c7_reg;
    assign dabs = dabs7_reg;

endmodule

>>> sv/mi3_div.sv
// ----------------------------------------------------------------------------
// mi3_div
// One divider lane: scales a cofactor magnitude, flags quotients that cannot
// fit, then resolves one quotient bit per stage by restoring division.
// ----------------------------------------------------------------------------
module mi3_div
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  mi3_ctl_t                      ctl_in,
    input  logic signed [2*DATA_WIDTH:0]  cof,
    input  logic [3*DATA_WIDTH-1:0]       dabs,
    output mi3_ctl_t                      ctl_out,
    output logic [DATA_WIDTH-1:0]         qmag
);

    localparam int D   = DATA_WIDTH;
    localparam int CW  = 2 * D + 1;
    localparam int DMW = 3 * D;
    localparam int NMW = 2 * D + 2 * FRAC_BITS;
    localparam int RW  = (NMW > 4 * D) ? NMW : 4 * D;

    logic [CW-1:0]  cabs;
    mi3_ctl_t       ctla_next;
    mi3_ctl_t       ctla_reg;
    logic [RW-1:0]  numa_reg;
    logic [DMW-1:0] da_reg;
    mi3_ctl_t       ctlb_next;

    logic [RW-1:0]  rem_reg [D];
    logic [DMW-1:0] d_reg   [D];
    logic [D-1:0]   q_reg   [D+1];
    mi3_ctl_t       ctl_reg [D+1];

    always_comb
    begin
        cabs          = cof[CW-1] ? CW'(-cof) : CW'(cof);
        ctla_next     = ctl_in;
        ctla_next.neg = ctl_in.neg ^ cof[CW-1];
        ctla_next.ovf = 1'b0;
        ctlb_next     = ctla_reg;
        ctlb_next.ovf = (numa_reg >= (RW'(da_reg) << D));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctla_reg   <= '0;
            ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            ctla_reg   <= ctla_next;
            ctl_reg[0] <= ctlb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numa_reg   <= RW'(cabs) << (2 * FRAC_BITS);
            da_reg     <= dabs;
            rem_reg[0] <= numa_reg;
            d_reg[0]   <= da_reg;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < D; k++)
    begin : g_stage
        localparam int BIT = D - 1 - k;

        logic [RW-1:0] dsh;
        logic          ge;
        logic [D-1:0]  qn;

        always_comb
        begin
            dsh     = RW'(d_reg[k]) << BIT;
            ge      = (rem_reg[k] >= dsh);
            qn      = q_reg[k];
            qn[BIT] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k+1] <= '0;
            end
            else if (en)
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1] <= qn;
            end
        end

        if (k < D - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? rem_reg[k] - dsh : rem_reg[k];
                    d_reg[k+1]   <= d_reg[k];
                end
            end
        end
    end

    assign ctl_out = ctl_reg[D];
    assign qmag    = q_reg[D];

endmodule
